FILE: rtl/core/atb2d_pkg.sv
// shared types, constants and fixed-point helpers for the 2d affine transform builder
// no dependencies; used by affine_transform_builder_2d and atb2d_checker
`default_nettype none

package atb2d_pkg;

  localparam int FRAC_BITS_DEF  = 16;
  localparam int ANGLE_BITS_DEF = 16;

  // odd taylor coefficients of sin(t*pi/2) in q30, lowest power first
  localparam logic [30:0] SIN_COEF [6] = '{
    31'd1686629713, 31'd693598668, 31'd85569306,
    31'd5026995, 31'd172272, 31'd3864
  };

  localparam logic [30:0] ONE_Q30 = 31'h4000_0000;

  // one item as it travels down the front of the pipeline
  typedef struct packed {
    logic               mode;
    logic               err;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] ox;
    logic signed [31:0] oy;
    logic signed [31:0] sx;
    logic signed [31:0] sy;
    logic signed [33:0] cx;
    logic signed [33:0] cy;
    logic signed [31:0] s;
    logic signed [31:0] c;
    logic signed [31:0] ra;
    logic signed [31:0] rb;
  } item_t;

  // clamp to the signed 32-bit range
  function automatic logic signed [31:0] sat32(input logic signed [67:0] x);
    logic signed [31:0] r;
    if (x > 68'sd2147483647) begin
      r = 32'sh7FFF_FFFF;
    end else if (x < -68'sd2147483648) begin
      r = 32'sh8000_0000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

  // round half up, then arithmetic shift right by n
  function automatic logic signed [67:0] rnd_shift(input logic signed [67:0] p,
                                                   input int n);
    logic signed [67:0] half;
    half = 68'sd1 <<< (n - 1);
    return (p + half) >>> n;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/affine_transform_builder_2d.sv
// 2d affine transform builder: sprite transform or camera view matrix per item
// depends on atb2d_pkg
`default_nettype none

// Fully pipelined: one item may be started every clock cycle and busy stays
// low. Each result comes out on m00..m12 and div_error with done high for one
// cycle. The depth of the pipeline is set by the two reciprocal dividers
// (2/width, -2/height), which resolve one quotient bit per pipeline stage;
// sine and cosine come from a polynomial pipeline running alongside them.
// Results leave in start order and cannot be held off.
module affine_transform_builder_2d #(
  parameter int FRAC_BITS  = atb2d_pkg::FRAC_BITS_DEF,
  parameter int ANGLE_BITS = atb2d_pkg::ANGLE_BITS_DEF
) (
  input  wire                         clk,
  input  wire                         rst,
  input  wire                         start,
  output logic                        busy,
  input  wire                         projection_mode,
  input  wire  signed [31:0]          pos_x,
  input  wire  signed [31:0]          pos_y,
  input  wire  signed [31:0]          origin_x,
  input  wire  signed [31:0]          origin_y,
  input  wire  signed [31:0]          scale_x,
  input  wire  signed [31:0]          scale_y,
  input  wire         [ANGLE_BITS-1:0] angle,
  output logic                        done,
  output logic signed [31:0]          m00,
  output logic signed [31:0]          m01,
  output logic signed [31:0]          m02,
  output logic signed [31:0]          m10,
  output logic signed [31:0]          m11,
  output logic signed [31:0]          m12,
  output logic                        div_error
);

  // numerator also has to hold the rounding term of a full 32-bit divisor
  localparam int DIV_W    = (2 * FRAC_BITS + 2 > 32) ? 2 * FRAC_BITS + 2 : 32;
  localparam int RCP      = DIV_W + 2;
  localparam int TRIG_LAT = 8;
  localparam int QW       = (DIV_W > 33) ? DIV_W : 33;

  atb2d_pkg::item_t st [0:RCP];
  atb2d_pkg::item_t item_in;
  logic [RCP:0]     vld;
  logic [3:1]       bv;

  logic [ANGLE_BITS-1:0] ang0;
  logic [1:0]            qd [1:7];
  logic [30:0]           t0;
  logic [30:0]           tt [2][1:6];
  logic [30:0]           t2 [2][1:6];
  logic [30:0]           hp [2][2:6];
  logic [31:0]           sq [2];
  logic [30:0]           fwd;
  logic [30:0]           back;
  logic signed [31:0]    s_sel;
  logic signed [31:0]    c_sel;

  logic [31:0]      dmag [2][1:DIV_W+1];
  logic [DIV_W-1:0] dnum [2][1:DIV_W+1];
  logic [31:0]      drem [2][1:DIV_W+1];
  logic [DIV_W-1:0] dquo [2][1:DIV_W+1];
  logic signed [31:0] ra_next;
  logic signed [31:0] rb_next;

  atb2d_pkg::item_t   b1_it;
  atb2d_pkg::item_t   b2_it;
  atb2d_pkg::item_t   b3_it;
  logic signed [33:0] pm [4];
  logic signed [35:0] qm [4];
  logic signed [33:0] pm2 [4];
  logic signed [67:0] rr [4];
  logic signed [31:0] u;
  logic signed [31:0] v;
  logic signed [34:0] mm0;
  logic signed [34:0] mm1;
  logic signed [34:0] mm3;
  logic signed [34:0] mm4;
  logic signed [67:0] mm2;
  logic signed [67:0] mm5;

  // never stalls
  assign busy = 1'b0;

  // valid bits follow the items
  always_ff @(posedge clk) begin
    if (rst) begin
      vld  <= '0;
      bv   <= '0;
      done <= 1'b0;
      div_error <= 1'b0;
    end else begin
      vld  <= {vld[RCP-1:0], start && !busy};
      bv   <= {bv[2:1], vld[RCP]};
      done <= bv[3];
      div_error <= bv[3] && b3_it.err;
    end
  end

  // incoming transfer
  always_comb begin
    item_in      = '0;
    item_in.mode = projection_mode;
    item_in.px   = pos_x;
    item_in.py   = pos_y;
    item_in.ox   = origin_x;
    item_in.oy   = origin_y;
    item_in.sx   = scale_x;
    item_in.sy   = scale_y;
  end

  // quarter-turn fraction in q30
  assign t0 = {1'b0, ang0[ANGLE_BITS-3:0], {(32 - ANGLE_BITS){1'b0}}};

  // sine polynomial lanes: lane 0 at t, lane 1 at one quarter turn minus t
  always_ff @(posedge clk) begin : trig_pipe
    logic [30:0] tv;
    logic [61:0] pr;
    for (int l = 0; l < 2; l++) begin
      tv = (l == 0) ? t0 : atb2d_pkg::ONE_Q30 - t0;
      pr = 62'(tv) * 62'(tv);
      tt[l][1] <= tv;
      t2[l][1] <= pr[60:30];
      pr = 62'(t2[l][1]) * 62'(atb2d_pkg::SIN_COEF[5]);
      hp[l][2] <= atb2d_pkg::SIN_COEF[4] - pr[60:30];
      tt[l][2] <= tt[l][1];
      t2[l][2] <= t2[l][1];
      for (int j = 3; j <= 6; j++) begin
        pr = 62'(t2[l][j-1]) * 62'(hp[l][j-1]);
        hp[l][j] <= atb2d_pkg::SIN_COEF[6-j] - pr[60:30];
        tt[l][j] <= tt[l][j-1];
        t2[l][j] <= t2[l][j-1];
      end
      pr = 62'(tt[l][6]) * 62'(hp[l][6]);
      sq[l] <= pr[61:30];
    end
  end

  // clamp and quadrant symmetry
  always_comb begin
    fwd  = (sq[0] > 32'(atb2d_pkg::ONE_Q30)) ? atb2d_pkg::ONE_Q30 : sq[0][30:0];
    back = (sq[1] > 32'(atb2d_pkg::ONE_Q30)) ? atb2d_pkg::ONE_Q30 : sq[1][30:0];
    case (qd[7])
      2'd0: begin
        s_sel = $signed({1'b0, fwd});
        c_sel = $signed({1'b0, back});
      end
      2'd1: begin
        s_sel = $signed({1'b0, back});
        c_sel = -$signed({1'b0, fwd});
      end
      2'd2: begin
        s_sel = -$signed({1'b0, fwd});
        c_sel = -$signed({1'b0, back});
      end
      default: begin
        s_sel = -$signed({1'b0, back});
        c_sel = $signed({1'b0, fwd});
      end
    endcase
  end

  // reciprocal dividers, one quotient bit per stage
  always_ff @(posedge clk) begin : div_pipe
    logic signed [31:0] sel;
    logic [31:0]        mg;
    logic [32:0]        rs;
    logic               ge;
    for (int d = 0; d < 2; d++) begin
      sel = (d == 0) ? st[0].ox : st[0].oy;
      mg  = sel[31] ? 32'(-sel) : 32'(sel);
      dmag[d][1] <= mg;
      dnum[d][1] <= (DIV_W'(1) << (2 * FRAC_BITS + 1)) + DIV_W'(mg >> 1);
      drem[d][1] <= '0;
      dquo[d][1] <= '0;
      for (int j = 2; j <= DIV_W + 1; j++) begin
        rs = {drem[d][j-1], dnum[d][j-1][DIV_W+1-j]};
        ge = rs >= {1'b0, dmag[d][j-1]};
        drem[d][j] <= ge ? 32'(rs - {1'b0, dmag[d][j-1]}) : rs[31:0];
        dquo[d][j] <= {dquo[d][j-1][DIV_W-2:0], ge};
        dmag[d][j] <= dmag[d][j-1];
        dnum[d][j] <= dnum[d][j-1];
      end
    end
  end

  // sign and saturation of 2/width and -2/height
  always_comb begin : rcp_sign
    logic [QW-1:0] qa;
    logic [QW-1:0] qb;
    logic          biga;
    logic          bigb;
    qa   = QW'(dquo[0][DIV_W+1]);
    qb   = QW'(dquo[1][DIV_W+1]);
    biga = qa >= (QW'(1) << 31);
    bigb = qb >= (QW'(1) << 31);
    if (st[RCP-1].ox[31]) begin
      ra_next = biga ? 32'sh8000_0000 : -$signed(qa[31:0]);
    end else begin
      ra_next = biga ? 32'sh7FFF_FFFF : $signed(qa[31:0]);
    end
    if (st[RCP-1].oy[31]) begin
      rb_next = bigb ? 32'sh7FFF_FFFF : $signed(qb[31:0]);
    end else begin
      rb_next = bigb ? 32'sh8000_0001 : -$signed(qb[31:0]);
    end
  end

  // front pipeline: item fields plus results merged at their stage
  always_ff @(posedge clk) begin : front_pipe
    atb2d_pkg::item_t nx;
    st[0] <= item_in;
    ang0  <= angle;
    for (int k = 0; k < RCP; k++) begin
      nx = st[k];
      if (k == 0) begin
        nx.cx  = -34'(st[0].px) + 34'(st[0].ox >>> 1);
        nx.cy  = -34'(st[0].py) + 34'(st[0].oy >>> 1);
        nx.err = st[0].mode && (st[0].ox == 32'sd0 || st[0].oy == 32'sd0);
      end
      if (k + 1 == TRIG_LAT) begin
        nx.s = s_sel;
        nx.c = c_sel;
      end
      if (k + 1 == RCP) begin
        nx.ra = ra_next;
        nx.rb = rb_next;
      end
      st[k+1] <= nx;
    end
    qd[1] <= ang0[ANGLE_BITS-1:ANGLE_BITS-2];
    for (int k = 1; k < 7; k++) begin
      qd[k+1] <= qd[k];
    end
  end

  // back stage 1: scale or reciprocal times trig, rotated camera offset
  always_ff @(posedge clk) begin : back1
    logic signed [31:0] x [4];
    logic signed [31:0] y [4];
    logic signed [67:0] p;
    atb2d_pkg::item_t   it;
    it = st[RCP];
    if (it.mode) begin
      x = '{it.ra, it.ra, it.rb, it.rb};
      y = '{it.c, it.s, it.s, it.c};
    end else begin
      x = '{it.sx, it.sy, it.sx, it.sy};
      y = '{it.c, it.c, -it.s, -it.s};
    end
    for (int i = 0; i < 4; i++) begin
      p = x[i] * y[i];
      pm[i] <= 34'(atb2d_pkg::rnd_shift(p, 30));
    end
    p = it.cx * it.c;
    qm[0] <= 36'(atb2d_pkg::rnd_shift(p, 30));
    p = it.cy * it.s;
    qm[1] <= 36'(atb2d_pkg::rnd_shift(p, 30));
    p = it.cx * it.s;
    qm[2] <= 36'(atb2d_pkg::rnd_shift(p, 30));
    p = it.cy * it.c;
    qm[3] <= 36'(atb2d_pkg::rnd_shift(p, 30));
    b1_it <= it;
  end

  // back stage 2: origin terms, saturated camera offset
  always_ff @(posedge clk) begin : back2
    logic signed [67:0] p;
    p = b1_it.ox * pm[0];
    rr[0] <= atb2d_pkg::rnd_shift(p, FRAC_BITS);
    p = b1_it.oy * pm[3];
    rr[1] <= atb2d_pkg::rnd_shift(p, FRAC_BITS);
    p = b1_it.ox * pm[2];
    rr[2] <= atb2d_pkg::rnd_shift(p, FRAC_BITS);
    p = b1_it.oy * pm[1];
    rr[3] <= atb2d_pkg::rnd_shift(p, FRAC_BITS);
    u <= atb2d_pkg::sat32(68'(qm[0]) + 68'(qm[1]));
    v <= atb2d_pkg::sat32(68'(qm[2]) - 68'(qm[3]));
    pm2   <= pm;
    b2_it <= b1_it;
  end

  // back stage 3: translation terms and coefficient selection
  always_ff @(posedge clk) begin : back3
    logic signed [67:0] p;
    if (b2_it.mode) begin
      p   = b2_it.ra * u;
      mm2 <= atb2d_pkg::rnd_shift(-p, FRAC_BITS);
      p   = b2_it.rb * v;
      mm5 <= atb2d_pkg::rnd_shift(p, FRAC_BITS);
      mm1 <= 35'(pm2[1]);
      mm4 <= 35'(pm2[3]);
    end else begin
      mm2 <= -rr[0] - rr[1] + 68'(b2_it.px);
      mm5 <= rr[2] - rr[3] + 68'(b2_it.py);
      mm1 <= 35'(pm2[3]);
      mm4 <= 35'(pm2[1]);
    end
    mm0   <= 35'(pm2[0]);
    mm3   <= -35'(pm2[2]);
    b3_it <= b2_it;
  end

  // output register: saturate, zero on bad camera size
  always_ff @(posedge clk) begin
    if (b3_it.err) begin
      m00 <= '0;
      m01 <= '0;
      m02 <= '0;
      m10 <= '0;
      m11 <= '0;
      m12 <= '0;
    end else begin
      m00 <= atb2d_pkg::sat32(68'(mm0));
      m01 <= atb2d_pkg::sat32(68'(mm1));
      m02 <= atb2d_pkg::sat32(mm2);
      m10 <= atb2d_pkg::sat32(68'(mm3));
      m11 <= atb2d_pkg::sat32(68'(mm4));
      m12 <= atb2d_pkg::sat32(mm5);
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/atb2d_checker.sv
// port-level checks for affine_transform_builder_2d, bound to the top level
// depends on atb2d_pkg
`default_nettype none

module atb2d_checker #(
  parameter int FRAC_BITS = atb2d_pkg::FRAC_BITS_DEF
) (
  input wire               clk,
  input wire               rst,
  input wire               start,
  input wire               busy,
  input wire               projection_mode,
  input wire               done,
  input wire               div_error,
  input wire signed [31:0] m00,
  input wire signed [31:0] m01,
  input wire signed [31:0] m02,
  input wire signed [31:0] m10,
  input wire signed [31:0] m11,
  input wire signed [31:0] m12
);

  localparam int LAT = (2 * FRAC_BITS + 9 > 39) ? 2 * FRAC_BITS + 9 : 39;

  // every start transfer comes out after the fixed latency
  a_start_done: assert property (@(posedge clk) disable iff (rst)
    start && !busy |-> ##LAT done)
    else $error("start transfer without result");

  // no result without a start transfer
  a_done_start: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, LAT))
    else $error("result without start transfer");

  // error only on a projection result
  a_err_mode: assert property (@(posedge clk) disable iff (rst)
    div_error |-> done && $past(projection_mode, LAT))
    else $error("div_error outside projection result");

  // error result carries a zero matrix
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    div_error |-> m00 == 32'sd0 && m01 == 32'sd0 && m02 == 32'sd0 &&
                  m10 == 32'sd0 && m11 == 32'sd0 && m12 == 32'sd0)
    else $error("nonzero matrix on div_error");

endmodule

bind affine_transform_builder_2d atb2d_checker #(.FRAC_BITS(FRAC_BITS)) u_atb2d_checker (
  .clk(clk), .rst(rst), .start(start), .busy(busy),
  .projection_mode(projection_mode), .done(done), .div_error(div_error),
  .m00(m00), .m01(m01), .m02(m02), .m10(m10), .m11(m11), .m12(m12)
);

`default_nettype wire

FILE: verif/testbench.sv
// self-checking testbench for affine_transform_builder_2d (sprite and camera view matrices)
// depends on atb2d_pkg and affine_transform_builder_2d; predicts each matrix in plain sv
`default_nettype none

// expected matrix for one start transfer
typedef struct {
  logic signed [31:0] m [6];
  logic               err;
} matrix_t;

// scoreboard: computes matrices from accepted items and checks the done outputs
class matrix_scoreboard;
  matrix_t pending[$];
  int      errors;

  // odd taylor coefficients of sin(t*pi/2), q30
  static const longint unsigned SIN_Q30[6] = '{
    64'd1686629713, 64'd693598668, 64'd85569306, 64'd5026995, 64'd172272, 64'd3864
  };

  static function longint sext(logic [31:0] v);
    return longint'(signed'(v));
  endfunction

  static function longint clamp32(longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  // round half up then floor shift
  static function longint round_shift(longint x, int n);
    return (x + (64'sd1 <<< (n - 1))) >>> n;
  endfunction

  static function longint quarter_sine(longint unsigned t);
    longint unsigned t2, p;
    t2 = (t * t) >> 30;
    p = SIN_Q30[5];
    for (int k = 4; k >= 0; k--) p = SIN_Q30[k] - ((t2 * p) >> 30);
    p = (t * p) >> 30;
    if (p > 64'd1073741824) p = 64'd1073741824;
    return longint'(p);
  endfunction

  static function void sin_cos(logic [15:0] ang, output longint s, output longint c);
    longint unsigned t;
    longint fwd, bck;
    t = longint'(ang[13:0]) << 16;
    fwd = quarter_sine(t);
    bck = quarter_sine(64'd1073741824 - t);
    case (ang[15:14])
      2'd0: begin s = fwd;  c = bck;  end
      2'd1: begin s = bck;  c = -fwd; end
      2'd2: begin s = -fwd; c = -bck; end
      default: begin s = -bck; c = fwd; end
    endcase
  endfunction

  // 2/d rounded, ties away from zero, clamped
  static function longint two_over(longint d);
    longint unsigned mag;
    longint q;
    mag = (d < 0) ? longint'(-d) : longint'(d);
    q = longint'(((64'd1 << 33) + (mag >> 1)) / mag);
    return clamp32(d < 0 ? -q : q);
  endfunction

  function void note_item(logic pm, logic [31:0] pxr, pyr, oxr, oyr, sxr, syr,
                          logic [15:0] ang);
    matrix_t e;
    longint px, py, ox, oy, sx, sy, s, c, r[6];
    longint sxc, syc, sxs, sys, a, b, cx, cy, u, v;
    px = sext(pxr); py = sext(pyr); ox = sext(oxr); oy = sext(oyr);
    sx = sext(sxr); sy = sext(syr);
    sin_cos(ang, s, c);
    e.err = 1'b0;
    if (!pm) begin
      sxc = round_shift(sx * c, 30); syc = round_shift(sy * c, 30);
      sxs = round_shift(sx * -s, 30); sys = round_shift(sy * -s, 30);
      r[0] = sxc;
      r[1] = sys;
      r[2] = -round_shift(ox * sxc, 16) - round_shift(oy * sys, 16) + px;
      r[3] = -sxs;
      r[4] = syc;
      r[5] = round_shift(ox * sxs, 16) - round_shift(oy * syc, 16) + py;
    end else if (ox == 0 || oy == 0) begin
      foreach (r[k]) r[k] = 0;
      e.err = 1'b1;
    end else begin
      a = two_over(ox);
      b = clamp32(-two_over(oy));
      cx = -px + (ox >>> 1);
      cy = -py + (oy >>> 1);
      u = clamp32(round_shift(cx * c, 30) + round_shift(cy * s, 30));
      v = clamp32(round_shift(cx * s, 30) - round_shift(cy * c, 30));
      r[0] = round_shift(a * c, 30);
      r[1] = round_shift(a * s, 30);
      r[2] = round_shift(-(a * u), 16);
      r[3] = -round_shift(b * s, 30);
      r[4] = round_shift(b * c, 30);
      r[5] = round_shift(b * v, 16);
    end
    foreach (r[k]) e.m[k] = clamp32(r[k]);
    pending.push_back(e);
  endfunction

  task automatic report(string what);
    $display("mismatch at %0t: %s", $realtime, what);
    errors++;
  endtask

  task automatic check_result(logic [31:0] got [6], logic got_err);
    matrix_t e;
    if (pending.size() == 0) begin
      report("result with no transfer pending");
      return;
    end
    e = pending.pop_front();
    foreach (got[k])
      if (got[k] !== e.m[k])
        report($sformatf("coefficient %0d got %h expected %h", k, got[k], e.m[k]));
    if (got_err !== e.err)
      report($sformatf("div_error got %b expected %b", got_err, e.err));
  endtask
endclass

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY = 41;
  localparam longint CYCLE_LIMIT = 200000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic projection_mode = 1'b0;
  logic signed [31:0] pos_x = '0, pos_y = '0, origin_x = '0, origin_y = '0;
  logic signed [31:0] scale_x = '0, scale_y = '0;
  logic [15:0] angle = '0;
  logic busy, done, div_error;
  logic signed [31:0] m00, m01, m02, m10, m11, m12;

  matrix_scoreboard board = new();
  longint cycles = 0;
  int send_idle_pct = 24;

  affine_transform_builder_2d dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .projection_mode(projection_mode), .pos_x(pos_x), .pos_y(pos_y),
    .origin_x(origin_x), .origin_y(origin_y), .scale_x(scale_x), .scale_y(scale_y),
    .angle(angle), .done(done), .m00(m00), .m01(m01), .m02(m02),
    .m10(m10), .m11(m11), .m12(m12), .div_error(div_error)
  );

  always #5 clk = ~clk;

  // note start transfers and check results at the rising edge
  always @(posedge clk) begin
    logic [31:0] got [6];
    cycles <= cycles + 1;
    if (!rst) begin
      if (start && !busy)
        board.note_item(projection_mode, pos_x, pos_y, origin_x, origin_y,
                        scale_x, scale_y, angle);
      if (done) begin
        got = '{m00, m01, m02, m10, m11, m12};
        board.check_result(got, div_error);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // drive one item and hold it until the transfer happens
  task automatic send_item(logic pm, logic [31:0] px, py, ox, oy, sx, sy,
                           logic [15:0] ang);
    while ($urandom_range(99) < send_idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    projection_mode <= pm;
    pos_x <= px; pos_y <= py; origin_x <= ox; origin_y <= oy;
    scale_x <= sx; scale_y <= sy; angle <= ang;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [31:0] pick_word();
    case ($urandom_range(7))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'(signed'($urandom_range(8)) - 4);
      3: return 32'($urandom_range(32'h0008_0000)) - 32'h0004_0000;
      4: return {{16{1'b0}}, 16'($urandom)} ^ {32{$urandom_range(1) == 1}};
      default: return $urandom;
    endcase
  endfunction

  task automatic send_random();
    logic pm;
    logic [31:0] ox, oy;
    pm = 1'($urandom_range(1));
    ox = pick_word();
    oy = pick_word();
    // mostly nonzero camera sizes, an occasional zero
    if (pm && $urandom_range(19) == 0) begin
      if ($urandom_range(1)) ox = '0; else oy = '0;
    end
    send_item(pm, pick_word(), pick_word(), ox, oy, pick_word(), pick_word(),
              16'($urandom));
  endtask

  task automatic drain();
    start <= 1'b0;
    while (board.pending.size() != 0) @(negedge clk);
  endtask

  initial begin
    logic [15:0] angs [8] = '{16'h0000, 16'h4000, 16'h8000, 16'hC000,
                              16'h3FFF, 16'h2000, 16'hFFFF, 16'h0001};
    repeat (4) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: quadrant boundaries, extremes, zero camera sizes
    foreach (angs[i])
      send_item(1'(i % 2), 32'h0001_0000, 32'hFFFF_0000, 32'h0010_0000, 32'h0008_0000,
                32'h0002_0000, 32'h0001_8000, angs[i]);
    send_item(1'b0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
              32'h7FFF_FFFF, 32'h8000_0000, 16'h2000);
    send_item(1'b0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
              32'h8000_0000, 32'h8000_0000, 16'hA000);
    send_item(1'b1, 32'h0, 32'h0, 32'h0, 32'h0010_0000, 32'h1, 32'h1, 16'h0);
    send_item(1'b1, 32'h0, 32'h0, 32'h0010_0000, 32'h0, 32'h1, 32'h1, 16'h0);
    send_item(1'b1, 32'h0, 32'h0, 32'h0, 32'h0, 32'h1, 32'h1, 16'h0);
    send_item(1'b1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h1, 32'hFFFF_FFFF,
              32'h0, 32'h0, 16'h6000);
    send_item(1'b1, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
              32'hFFFF_FFFF, 32'h0, 16'hE000);
    send_item(1'b1, 32'h0, 32'h0, 32'h2, 32'hFFFF_FFFE, 32'h0, 32'h0, 16'h1234);

    // pause until every expected matrix has come out
    drain();

    // random phases: sender idles lightly, then heavily, then back to back
    repeat (420) send_random();
    send_idle_pct = 83;
    repeat (420) send_random();
    send_idle_pct = 0;
    repeat (400) send_random();

    drain();
    repeat (LATENCY + 10) @(negedge clk);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule

`default_nettype wire

FILE: filelist.f
rtl/core/atb2d_pkg.sv
rtl/core/affine_transform_builder_2d.sv
rtl/core/atb2d_checker.sv
verif/testbench.sv
